### hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the sortable value store RTL.
// SVS_CHECK expects signals named clk and rst in the calling scope; SVS_CHECK_ALWAYS needs only clk.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside of reset.
`define SVS_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define SVS_CHECK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/svs_pkg.sv
// ---------------------------------------------------------------------------
// svs_pkg
// Types and constants shared by the sortable value store modules.
// ---------------------------------------------------------------------------
package svs_pkg;

  localparam int VALUE_W   = 32;
  localparam int DEPTH_DEF = 32;

  typedef enum logic [2:0] {
    CMD_APPEND    = 3'd0,
    CMD_SORT_UP   = 3'd1,
    CMD_SORT_DOWN = 3'd2,
    CMD_COUNT     = 3'd3,
    CMD_READ      = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_COUNT = 2'd0,
    KIND_ELEM  = 2'd1,
    KIND_FULL  = 2'd2,
    KIND_BAD   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_LOAD   = 2'd1,
    CELL_ROTATE = 2'd2,
    CELL_SORT   = 2'd3
  } cell_op_t;

  // Control broadcast to every cell of the row.
  typedef struct packed {
    cell_op_t op;
    logic     phase;  // odd-even pass: 0 pairs even cells with their right
    logic     down;   // descending order when set
  } cell_ctrl_t;

endpackage

### hw/rtl/svs_cell.sv
// ---------------------------------------------------------------------------
// svs_cell
// One storage cell of the row: load, rotate toward cell zero, or take part
// in an odd-even compare-exchange with one neighbor.
// ---------------------------------------------------------------------------
module svs_cell
  import svs_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  parameter int IDX   = 0,
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic                      clk,
  input  cell_ctrl_t                ctrl,
  input  logic [CW-1:0]             fill,
  input  logic signed [VALUE_W-1:0] load_value,
  input  logic signed [VALUE_W-1:0] left,
  input  logic signed [VALUE_W-1:0] right,
  output logic signed [VALUE_W-1:0] q
);

  localparam logic          ODD      = ((IDX % 2) == 1);
  localparam logic [CW-1:0] MY_IDX   = CW'(IDX);
  localparam logic [CW-1:0] NEXT_IDX = CW'(IDX + 1);
  localparam logic          HAS_LEFT = (IDX > 0);

  logic                      lower;
  logic                      upper;
  logic signed [VALUE_W-1:0] q_next;

  // Lower partner of a pair keeps the first element, upper keeps the second.
  assign lower = (ctrl.phase == ODD) && (NEXT_IDX < fill);
  assign upper = HAS_LEFT && (ctrl.phase != ODD) && (MY_IDX < fill);

  always_comb begin
    q_next = q;
    unique case (ctrl.op)
      CELL_HOLD: begin
        q_next = q;
      end
      CELL_LOAD: begin
        if (MY_IDX == fill) begin
          q_next = load_value;
        end
      end
      CELL_ROTATE: begin
        q_next = right;
      end
      CELL_SORT: begin
        if (lower) begin
          if (ctrl.down ? (q < right) : (q > right)) begin
            q_next = right;
          end
        end else if (upper) begin
          if (ctrl.down ? (left < q) : (left > q)) begin
            q_next = left;
          end
        end
      end
      default: begin
        q_next = q;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

### hw/rtl/svs_ctrl.sv
// ---------------------------------------------------------------------------
// svs_ctrl
// Command sequencer: fill count, pass counter, cell control and the
// registered result ports.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module svs_ctrl
  import svs_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [2:0]                command,
  input  logic signed [VALUE_W-1:0] head_value,
  output logic                      busy,
  output cell_ctrl_t                cell_ctrl,
  output logic [CW-1:0]             fill,
  output logic                      strobe,
  output logic [1:0]                kind,
  output logic signed [VALUE_W-1:0] data,
  output logic                      last
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SORT,
    S_READ
  } state_t;

  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [CW-1:0] LAST_C  = CW'(DEPTH - 1);

  state_t        state;
  logic [CW-1:0] cnt;
  logic          dir;
  logic          accept;
  logic          full;

  assign accept = start && !busy;
  assign full   = (fill == DEPTH_C);
  assign busy   = (state != S_IDLE);

  always_comb begin
    cell_ctrl.op    = CELL_HOLD;
    cell_ctrl.phase = cnt[0];
    cell_ctrl.down  = dir;
    unique case (state)
      S_IDLE: begin
        if (accept && (command == CMD_APPEND) && !full) begin
          cell_ctrl.op = CELL_LOAD;
        end
      end
      S_SORT: cell_ctrl.op = CELL_SORT;
      S_READ: cell_ctrl.op = CELL_ROTATE;
      default: cell_ctrl.op = CELL_HOLD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      fill   <= '0;
      cnt    <= '0;
      dir    <= 1'b0;
      strobe <= 1'b0;
      kind   <= KIND_COUNT;
      data   <= '0;
      last   <= 1'b0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        S_IDLE: begin
          cnt <= '0;
          if (accept) begin
            unique case (command)
              CMD_APPEND: begin
                if (full) begin
                  strobe <= 1'b1;
                  kind   <= KIND_FULL;
                  data   <= '0;
                  last   <= 1'b1;
                end else begin
                  fill <= fill + 1'b1;
                end
              end
              CMD_SORT_UP: begin
                dir   <= 1'b0;
                state <= S_SORT;
              end
              CMD_SORT_DOWN: begin
                dir   <= 1'b1;
                state <= S_SORT;
              end
              CMD_COUNT: begin
                strobe <= 1'b1;
                kind   <= KIND_COUNT;
                data   <= VALUE_W'(fill);
                last   <= 1'b1;
              end
              CMD_READ: begin
                state <= S_READ;
              end
              default: begin
                strobe <= 1'b1;
                kind   <= KIND_BAD;
                data   <= '0;
                last   <= 1'b1;
              end
            endcase
          end
        end
        S_SORT: begin
          cnt <= cnt + 1'b1;
          if (cnt == LAST_C) begin
            state <= S_IDLE;
          end
        end
        S_READ: begin
          // Cell zero holds element cnt while the row rotates.
          if (cnt < fill) begin
            strobe <= 1'b1;
            kind   <= KIND_ELEM;
            data   <= head_value;
            last   <= (cnt == fill - 1'b1);
          end
          cnt <= cnt + 1'b1;
          if (cnt == LAST_C) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `SVS_CHECK(a_fill_bound, fill <= DEPTH_C, "fill count beyond depth")
  `SVS_CHECK(a_full_err, (accept && (command == CMD_APPEND) && full) |=> (strobe && (kind == KIND_FULL)), "append to full store gave no error")
  `SVS_CHECK(a_single_last, (strobe && (kind != KIND_ELEM)) |-> last, "single result not marked last")
  `SVS_CHECK(a_elem_in_read, (strobe && (kind == KIND_ELEM)) |-> ($past(state) == S_READ), "element result outside read")
  `SVS_CHECK_ALWAYS(a_reset_idle, rst |=> (!busy && !strobe && (fill == '0)), "reset did not clear control")

endmodule

### hw/rtl/sortable_value_store.sv
// ---------------------------------------------------------------------------
// sortable_value_store
// Command-driven store of up to DEPTH signed values, held in a row of cells
// that sorts by odd-even transposition and reads out by rotation.
// ---------------------------------------------------------------------------
//
//   Channel   Signals                      Handshake
//   -------   --------------------------   ------------------------------
//   command   start, command, value        item taken when start && !busy
//   result    strobe, kind, data, last     item valid for one cycle only
//
// Append, count and invalid commands never raise busy; their one result,
// if any, is on the ports in the cycle after the item is taken.
// Sort and read-out hold busy until the pass counter reaches the row end: a
// sort runs DEPTH odd-even passes, a read-out rotates the row once and
// registers each element from cell zero onto the ports, in order.
// Reset clears only the fill count and sequencer; the receiver cannot stall.
// ---------------------------------------------------------------------------
module sortable_value_store
  import svs_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [2:0]                command,
  input  logic signed [VALUE_W-1:0] value,
  output logic                      strobe,
  output logic [1:0]                kind,
  output logic signed [VALUE_W-1:0] data,
  output logic                      last
);

  localparam int CW = $clog2(DEPTH + 1);

  cell_ctrl_t                cell_ctrl;
  logic [CW-1:0]             fill;
  logic signed [VALUE_W-1:0] q [DEPTH];

  // The sequencer owns the fill count and drives one control word to
  // every cell; it samples cell zero during a read-out.
  svs_ctrl #(
    .DEPTH (DEPTH),
    .CW    (CW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .command    (command),
    .head_value (q[0]),
    .busy       (busy),
    .cell_ctrl  (cell_ctrl),
    .fill       (fill),
    .strobe     (strobe),
    .kind       (kind),
    .data       (data),
    .last       (last)
  );

  // Each cell sees both neighbors. The last cell's right neighbor wraps to
  // cell zero so that a rotation is lossless; cell zero has no left partner.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [VALUE_W-1:0] left_v;
    logic signed [VALUE_W-1:0] right_v;

    if (i == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_mid
      assign left_v = q[i-1];
    end

    if (i == DEPTH - 1) begin : g_wrap
      assign right_v = q[0];
    end else begin : g_next
      assign right_v = q[i+1];
    end

    svs_cell #(
      .DEPTH (DEPTH),
      .IDX   (i),
      .CW    (CW)
    ) u_cell (
      .clk        (clk),
      .ctrl       (cell_ctrl),
      .fill       (fill),
      .load_value (value),
      .left       (left_v),
      .right      (right_v),
      .q          (q[i])
    );
  end

endmodule
